>>> sv/epc_pkg.sv
// shared types, codes and crc function for the e2e pdu protect and check block
package epc_pkg;

   localparam int DataWidth     = 8;
   localparam int CounterWidth  = 4;
   localparam int PduLenWidth   = 7;
   localparam int StatusWidth   = 2;
   localparam int CsrIndexWidth = 2;

   localparam logic [DataWidth-1:0] CrcPoly   = 8'h1D;
   localparam logic [DataWidth-1:0] CrcInit   = 8'hFF;
   localparam logic [DataWidth-1:0] CrcXorOut = 8'hFF;

   localparam logic [StatusWidth-1:0] StOk       = 2'd0;
   localparam logic [StatusWidth-1:0] StRepeated = 2'd1;
   localparam logic [StatusWidth-1:0] StWrongSeq = 2'd2;
   localparam logic [StatusWidth-1:0] StError    = 2'd3;

   localparam logic OpProtect = 1'b0;
   localparam logic OpCheck   = 1'b1;

   localparam logic [CsrIndexWidth-1:0] CsrDataId    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPduLength = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrMaxGap    = 2'd2;

   typedef struct packed {
      logic [DataWidth-1:0]    data_id;
      logic [PduLenWidth-1:0]  pdu_length;
      logic [CounterWidth-1:0] max_gap;
   } cfg_type;

   typedef struct packed {
      logic                 op;
      logic                 len_ok;
      logic [DataWidth-1:0] crc;
      logic [DataWidth-1:0] header;
      logic [DataWidth-1:0] rx_crc;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [DataWidth-1:0] crc_fold(input logic [DataWidth-1:0] c,
                                                     input logic [DataWidth-1:0] b);
      logic [DataWidth-1:0] r;
      r = c ^ b;
      for (int k = 0; k < DataWidth; k++) begin
         if (r[DataWidth-1]) begin
            r = {r[DataWidth-2:0], 1'b0} ^ CrcPoly;
         end else begin
            r = {r[DataWidth-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

>>> sv/epc_front.sv
// front end: takes pdu bytes, counts length, runs payload crc, queues one record per pdu
module epc_front #(
   parameter int MAX_PDU_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  epc_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_operation,
   input  logic [epc_pkg::DataWidth-1:0] req_data_byte,
   input  logic                          req_last_byte,
   output logic                          push,
   output epc_pkg::rec_type              push_rec
);
   import epc_pkg::*;

   localparam int IdxW = $clog2(MAX_PDU_BYTES + 1);
   localparam int LenW = $clog2(MAX_PDU_BYTES + 2);
   localparam int CmpW = (LenW > PduLenWidth) ? LenW : PduLenWidth;

   logic [IdxW-1:0]      idx_ff, idx_in;
   logic [DataWidth-1:0] crc_ff, crc_in;
   logic [DataWidth-1:0] hdr_ff, hdr_in;
   logic [DataWidth-1:0] rxcrc_ff, rxcrc_in;
   logic [DataWidth-1:0] crc_next;
   logic [LenW-1:0]      len;
   logic                 accept;
   logic                 len_ok;

   assign accept = req_valid && !req_stall;
   assign len    = LenW'(idx_ff) + LenW'(1);
   assign len_ok = (len >= LenW'(2)) && (len <= LenW'(MAX_PDU_BYTES))
                   && (CmpW'(len) == CmpW'(cfg.pdu_length));

   always_comb begin
      hdr_in   = hdr_ff;
      rxcrc_in = rxcrc_ff;
      crc_next = crc_ff;
      if (idx_ff == IdxW'(0)) begin
         hdr_in = req_data_byte;
      end else if (idx_ff == IdxW'(1)) begin
         rxcrc_in = req_data_byte;
      end else begin
         crc_next = crc_fold(crc_ff, req_data_byte);
      end
      if (req_last_byte) begin
         idx_in = '0;
         crc_in = CrcInit;
      end else begin
         crc_in = crc_next;
         if (idx_ff < IdxW'(MAX_PDU_BYTES)) begin
            idx_in = idx_ff + IdxW'(1);
         end else begin
            idx_in = idx_ff;
         end
      end
   end

   assign push            = accept && req_last_byte;
   assign push_rec.op     = req_operation;
   assign push_rec.len_ok = len_ok;
   assign push_rec.crc    = crc_next;
   assign push_rec.header = hdr_in;
   assign push_rec.rx_crc = rxcrc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         crc_ff   <= CrcInit;
         hdr_ff   <= '0;
         rxcrc_ff <= '0;
      end else if (accept) begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         hdr_ff   <= hdr_in;
         rxcrc_ff <= rxcrc_in;
      end
   end

endmodule

>>> sv/epc_queue.sv
// two-entry record queue between front and back
module epc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  epc_pkg::rec_type      push_rec,
   input  logic                  pop,
   output epc_pkg::rec_type      pop_rec,
   output epc_pkg::q_status_type status
);
   import epc_pkg::*;

   rec_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign pop_rec      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/epc_back.sv
// back end: finishes crc, runs protect or check, keeps alive counter, holds result
module epc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  epc_pkg::cfg_type                 cfg,
   input  epc_pkg::q_status_type            q_status,
   input  epc_pkg::rec_type                 rec,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [epc_pkg::StatusWidth-1:0]  rsp_status,
   output logic [epc_pkg::DataWidth-1:0]    rsp_header_byte,
   output logic [epc_pkg::DataWidth-1:0]    rsp_crc_byte,
   output logic [epc_pkg::CounterWidth-1:0] rsp_alive_count
);
   import epc_pkg::*;

   logic                    valid_ff;
   logic [StatusWidth-1:0]  status_ff, status_in;
   logic [DataWidth-1:0]    header_ff, header_in;
   logic [DataWidth-1:0]    crc_ff, crc_in;
   logic [CounterWidth-1:0] alive_ff, alive_in;
   logic [DataWidth-1:0]    crc_final;
   logic [CounterWidth-1:0] rx_count, delta;

   assign pop       = !q_status.empty && (!valid_ff || !rsp_stall);
   assign crc_final = crc_fold(rec.crc, cfg.data_id) ^ CrcXorOut;
   assign rx_count  = rec.header[DataWidth-1:CounterWidth];
   assign delta     = rx_count - alive_ff;

   always_comb begin
      alive_in  = alive_ff;
      status_in = StError;
      header_in = '0;
      crc_in    = '0;
      if (rec.op == OpProtect) begin
         if (rec.len_ok) begin
            alive_in  = alive_ff + CounterWidth'(1);
            header_in = {alive_in, cfg.data_id[CounterWidth-1:0]};
            crc_in    = crc_final;
            status_in = StOk;
         end
      end else begin
         header_in = rec.header;
         if (rec.len_ok) begin
            crc_in = crc_final;
            if ((rec.header[CounterWidth-1:0] == cfg.data_id[CounterWidth-1:0])
                && (rec.rx_crc == crc_final)) begin
               alive_in = rx_count;
               if (delta == CounterWidth'(0)) begin
                  status_in = StRepeated;
               end else if (delta == CounterWidth'(1)) begin
                  status_in = StOk;
               end else if (delta > cfg.max_gap) begin
                  status_in = StWrongSeq;
               end else begin
                  status_in = StOk;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         alive_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            alive_ff <= alive_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         header_ff <= header_in;
         crc_ff    <= crc_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_header_byte = header_ff;
   assign rsp_crc_byte    = crc_ff;
   assign rsp_alive_count = alive_ff;

endmodule

>>> sv/e2e_pdu_protect_check.sv
// top level of the e2e pdu protect and check block
//
//   channel  direction  handshake             item
//   req_     in         req_valid/req_stall   one pdu byte with operation and last flag
//   rsp_     out        rsp_valid/rsp_stall   one result per pdu, on its last byte
//   csr_     in         csr_write_enable      register write, index and data
//
// one byte per cycle unless stalled; a pdu record is queued, then registered in the back
// the front counts bytes and folds the payload crc, the back finishes crc and counter
// synchronous reset clears counters, queue and result valid; registers go to defaults
// req_stall rises only when the two-entry record queue is full
// a stalled result holds while the front keeps taking bytes until the queue is full
module e2e_pdu_protect_check #(
   parameter int MAX_PDU_BYTES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [epc_pkg::DataWidth-1:0]      req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [epc_pkg::StatusWidth-1:0]    rsp_status,
   output logic [epc_pkg::DataWidth-1:0]      rsp_header_byte,
   output logic [epc_pkg::DataWidth-1:0]      rsp_crc_byte,
   output logic [epc_pkg::CounterWidth-1:0]   rsp_alive_count,
   input  logic                               csr_write_enable,
   input  logic [epc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [epc_pkg::DataWidth-1:0]      csr_write_data
);
   import epc_pkg::*;

   cfg_type      cfg_ff;
   rec_type      push_rec, pop_rec;
   q_status_type q_status;
   logic         push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_id    <= '0;
         cfg_ff.pdu_length <= PduLenWidth'(8);
         cfg_ff.max_gap    <= CounterWidth'(2);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrDataId: begin
               cfg_ff.data_id <= csr_write_data;
            end
            CsrPduLength: begin
               cfg_ff.pdu_length <= csr_write_data[PduLenWidth-1:0];
            end
            CsrMaxGap: begin
               cfg_ff.max_gap <= csr_write_data[CounterWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = q_status.full;

   epc_front #(
      .MAX_PDU_BYTES(MAX_PDU_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push          (push),
      .push_rec      (push_rec)
   );

   epc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .status   (q_status)
   );

   epc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_status        (q_status),
      .rec             (pop_rec),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_header_byte (rsp_header_byte),
      .rsp_crc_byte    (rsp_crc_byte),
      .rsp_alive_count (rsp_alive_count)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("record pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("record popped from empty queue");

   a_counter_in_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StError)
      |-> (rsp_alive_count == rsp_header_byte[DataWidth-1:CounterWidth]))
      else $error("alive count does not match header counter");
`endif

endmodule
